// ===== hdl/b2da_pkg.sv =====
package b2da_pkg;

	// Conversion steps folded into one pipeline stage
	localparam int unsigned STEPS_PER_STAGE = 4;

	localparam logic [5:0] ASCII_ZERO = 6'd48;

	// Add-3 correction applied to a BCD digit before each shift
	function automatic logic [3:0] b2da_fix(input logic [3:0] d);
		logic [3:0] r;
		r = (d >= 4'd5) ? d + 4'd3 : d;
		return r;
	endfunction

endpackage

// ===== hdl/binary_to_decimal_ascii_unit.sv =====
// A request passes ceil(VALUE_WIDTH/4) conversion stages, then the digit register;
// back-pressure can hold it in any of them. Throughput: a request may enter every
// cycle unless the stages are stalled; the output sends one digit per cycle while
// m_tready is high, holding a request until its digits (1 to 5 at 16 bits) are sent.
// Reset clears all valid bits and the digit count; no request is in flight afterward.
module binary_to_decimal_ascii_unit import b2da_pkg::*; #(
	parameter int unsigned VALUE_WIDTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((VALUE_WIDTH+7)/8)*8-1:0]       s_tdata, // value, zero fill
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [7:0]                             m_tdata, // digit_char[5:0], zero fill
	output logic                                   m_tlast  // last_digit
);

	localparam int unsigned NDIG   = (VALUE_WIDTH * 301) / 1000 + 1;
	localparam int unsigned BCD_W  = NDIG * 4;
	localparam int unsigned NSTAGE = (VALUE_WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
	localparam int unsigned CNT_W  = $clog2(NDIG + 1);
	localparam int unsigned IDX_W  = $clog2(NDIG);

	logic                   vld   [NSTAGE+1];
	logic                   rdy   [NSTAGE+1];
	logic [VALUE_WIDTH-1:0] bin   [NSTAGE+1];
	logic [BCD_W-1:0]       bcd   [NSTAGE+1];

	assign vld[0]   = s_tvalid;
	assign s_tready = rdy[0];
	assign bin[0]   = s_tdata[VALUE_WIDTH-1:0];
	assign bcd[0]   = '0;

	for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
		b2da_stage #(
			.VALUE_WIDTH(VALUE_WIDTH),
			.NDIG       (NDIG),
			.FIRST_STEP (g * STEPS_PER_STAGE)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (vld[g]),
			.in_ready (rdy[g]),
			.in_bin   (bin[g]),
			.in_bcd   (bcd[g]),
			.out_valid(vld[g+1]),
			.out_ready(rdy[g+1]),
			.out_bin  (bin[g+1]),
			.out_bcd  (bcd[g+1])
		);
	end

	// Digit serializer
	logic [3:0]       dig_q [NDIG];
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] sig_cnt;
	logic             load_ok;
	logic [IDX_W-1:0] idx;
	logic [3:0]       cur_dig;

	// Count significant digits; zero still sends one
	always_comb begin
		sig_cnt = CNT_W'(1);
		for (int d = 1; d < NDIG; d++) begin
			if (bcd[NSTAGE][d*4 +: 4] != 4'd0) begin
				sig_cnt = CNT_W'(d + 1);
			end
		end
	end

	assign load_ok      = (cnt_q == '0) || (m_tready && cnt_q == CNT_W'(1));
	assign rdy[NSTAGE]  = load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load_ok) begin
			cnt_q <= vld[NSTAGE] ? sig_cnt : '0;
		end else if (m_tready) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok && vld[NSTAGE]) begin
			for (int d = 0; d < NDIG; d++) begin
				dig_q[d] <= bcd[NSTAGE][d*4 +: 4];
			end
		end
	end

	assign idx      = IDX_W'(cnt_q - CNT_W'(1));
	assign cur_dig  = dig_q[idx];
	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = {2'b00, ASCII_ZERO + {2'b00, cur_dig}};
	assign m_tlast  = (cnt_q == CNT_W'(1));

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[5:0] >= 6'd48 && m_tdata[5:0] <= 6'd57))
		else $error("digit out of range");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(NDIG))
		else $error("digit count overflow");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
		else $error("digit run cut short");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast && !vld[NSTAGE]) |=> !m_tvalid)
		else $error("output valid without request");

endmodule

// ===== hdl/b2da_stage.sv =====
module b2da_stage import b2da_pkg::*; #(
	parameter int unsigned VALUE_WIDTH = 16,
	parameter int unsigned NDIG        = 5,
	parameter int unsigned FIRST_STEP  = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [VALUE_WIDTH-1:0] in_bin,
	input  logic [NDIG*4-1:0]      in_bcd,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [VALUE_WIDTH-1:0] out_bin,
	output logic [NDIG*4-1:0]      out_bcd
);

	localparam int unsigned BCD_W = NDIG * 4;

	logic                   valid_s1;
	logic [VALUE_WIDTH-1:0] bin_s1;
	logic [BCD_W-1:0]       bcd_s1;
	logic [VALUE_WIDTH-1:0] bin_nxt;
	logic [BCD_W-1:0]       bcd_nxt;

	// Run this stage's share of the shift-add-3 steps
	always_comb begin
		bin_nxt = in_bin;
		bcd_nxt = in_bcd;
		for (int s = 0; s < STEPS_PER_STAGE; s++) begin
			if (FIRST_STEP + s < VALUE_WIDTH) begin
				for (int d = 0; d < NDIG; d++) begin
					bcd_nxt[d*4 +: 4] = b2da_fix(bcd_nxt[d*4 +: 4]);
				end
				bcd_nxt = {bcd_nxt[BCD_W-2:0], bin_nxt[VALUE_WIDTH-1]};
				bin_nxt = {bin_nxt[VALUE_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			bin_s1 <= bin_nxt;
			bcd_s1 <= bcd_nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_bin   = bin_s1;
	assign out_bcd   = bcd_s1;

endmodule
